### hw/rtl/fsr_pkg.sv
// ----------------------------------------------------------------------------
// fsr_pkg
// Shared constants, codes and types of the frame segment reassembler.
// ----------------------------------------------------------------------------
package fsr_pkg;

    localparam int FRAME_BYTES   = 1024;
    localparam int SEGMENT_BYTES = 200;
    localparam int MAX_SEGMENTS  = 6;

    localparam int FRAME_AW  = $clog2(FRAME_BYTES);
    localparam int LANE_W    = 3;
    localparam int ROW_BYTES = 1 << LANE_W;
    localparam int ROW_W     = 8 * ROW_BYTES;
    localparam int ROW_AW    = FRAME_AW - LANE_W;
    localparam int ROWS      = 1 << ROW_AW;
    localparam int ADDR_W    = ROW_AW + 1;
    localparam int SEG_W     = 3;
    localparam int CNT_W     = $clog2(MAX_SEGMENTS + 1);
    localparam int POS_W     = 13;

    localparam logic [1:0] ACT_SEGMENT    = 2'd0;
    localparam logic [1:0] ACT_READ       = 2'd1;
    localparam logic [1:0] ACT_REMOTE_ON  = 2'd2;
    localparam logic [1:0] ACT_REMOTE_OFF = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_COMPLETE    = 3'd1;
    localparam logic [2:0] ST_NOT_REMOTE  = 3'd2;
    localparam logic [2:0] ST_BAD_TOTAL   = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX   = 3'd4;
    localparam logic [2:0] ST_NO_FRAME    = 3'd5;
    localparam logic [2:0] ST_DUPLICATE   = 3'd6;
    localparam logic [2:0] ST_BEYOND_END  = 3'd7;

    typedef struct packed {
        logic              en;
        logic              bank;
        logic [ROW_AW-1:0] row;
        logic [1:0]        clr;
    } mem_req_t;

    typedef struct packed {
        logic              en;
        logic [LANE_W-1:0] lane;
        logic [7:0]        data;
    } mem_wr_t;

endpackage

### hw/rtl/frame_segment_reassembler.sv
// ----------------------------------------------------------------------------
// frame_segment_reassembler
// Rebuilds a display frame from numbered segments, one byte per transfer, in a
// row memory with an assembly bank and a shown bank that swap on completion.
// ----------------------------------------------------------------------------
// Each result is held in the s1 registers and then in the output registers.
// Throughput: one transfer per cycle while the output is not stalled, set by
// the single read-modify-write path of the row memory, which forwards a row
// written in the same cycle as the read of the next transfer.
// Reset clears all control state and the row valid bits, so both stores read
// as zero at once; no clearing pass is needed and input is taken right away.
// ----------------------------------------------------------------------------
module frame_segment_reassembler (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [7:0] seg_index,
    input  logic [7:0] seg_total,
    input  logic [7:0] byte_offset,
    input  logic [7:0] byte_value,
    input  logic       segment_end,
    input  logic [9:0] read_address,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [7:0] read_data,
    output logic       frame_done,
    output logic       refresh_screen
);
    import fsr_pkg::*;

    logic                     suppress_reg;
    logic                     remote_reg;
    logic                     remote_next;
    logic                     open_reg;
    logic                     open_next;
    logic [CNT_W-1:0]         expected_reg;
    logic [CNT_W-1:0]         expected_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [MAX_SEGMENTS-1:0]  mask_reg;
    logic [MAX_SEGMENTS-1:0]  mask_next;
    logic                     sel_reg;
    logic                     sel_next;

    logic                     s1_valid_reg;
    logic [2:0]               s1_status_reg;
    logic                     s1_done_reg;
    logic                     s1_refresh_reg;
    logic                     s1_read_reg;
    logic                     s1_wr_reg;
    logic [LANE_W-1:0]        s1_lane_reg;
    logic [7:0]               s1_value_reg;

    logic                     out_valid_reg;
    logic [2:0]               out_status_reg;
    logic [7:0]               out_data_reg;
    logic                     out_done_reg;
    logic                     out_refresh_reg;

    logic                     out_free;
    logic                     s1_adv;
    logic                     accept;

    logic [SEG_W-1:0]         seg_sel;
    logic [POS_W-1:0]         base;
    logic [POS_W-1:0]         pos;
    logic [POS_W-1:0]         rd_pos;
    logic [POS_W-1:0]         frame_end;
    logic                     total_bad;
    logic                     idx_bad;
    logic                     restart;
    logic [MAX_SEGMENTS-1:0]  seg_bit;

    logic [2:0]               status_c;
    logic                     done_c;
    logic                     refresh_c;
    logic                     read_c;
    logic                     wr_c;
    logic [LANE_W-1:0]        lane_c;
    logic                     eff_open;
    logic [CNT_W-1:0]         eff_expected;
    logic [CNT_W-1:0]         eff_count;
    logic [MAX_SEGMENTS-1:0]  eff_mask;
    logic [CNT_W:0]           count_inc;

    mem_req_t                 req;
    mem_wr_t                  wr;
    logic [ROW_W-1:0]         row_data;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign accept   = in_valid && in_ready;

    assign seg_sel   = seg_index[SEG_W-1:0];
    assign base      = POS_W'(seg_sel) * POS_W'(SEGMENT_BYTES);
    assign pos       = base + POS_W'(byte_offset);
    assign rd_pos    = POS_W'(read_address);
    assign frame_end = POS_W'(FRAME_BYTES);
    assign total_bad = (seg_total == 8'd0) || (seg_total > 8'(MAX_SEGMENTS));
    assign idx_bad   = (seg_index >= seg_total) || (base >= frame_end);
    assign restart   = (seg_index == 8'd0) && (byte_offset == 8'd0);
    assign seg_bit   = MAX_SEGMENTS'(1) << seg_sel;

    always_comb
    begin
        status_c      = ST_OK;
        done_c        = 1'b0;
        refresh_c     = 1'b0;
        read_c        = 1'b0;
        wr_c          = 1'b0;
        lane_c        = pos[LANE_W-1:0];
        remote_next   = remote_reg;
        open_next     = open_reg;
        expected_next = expected_reg;
        count_next    = count_reg;
        mask_next     = mask_reg;
        sel_next      = sel_reg;
        eff_open      = open_reg;
        eff_expected  = expected_reg;
        eff_count     = count_reg;
        eff_mask      = mask_reg;
        count_inc     = {1'b0, count_reg} + 1'b1;
        req.en        = 1'b0;
        req.bank      = sel_reg;
        req.row       = pos[FRAME_AW-1:LANE_W];
        req.clr       = 2'b00;

        case (action)
            ACT_SEGMENT:
            begin
                if (!remote_reg)
                begin
                    status_c = ST_NOT_REMOTE;
                end
                else if (total_bad)
                begin
                    status_c = ST_BAD_TOTAL;
                end
                else if (idx_bad)
                begin
                    status_c = ST_BAD_INDEX;
                end
                else
                begin
                    if (restart)
                    begin
                        eff_open     = 1'b1;
                        eff_expected = seg_total[CNT_W-1:0];
                        eff_count    = '0;
                        eff_mask     = '0;
                        req.clr[sel_reg] = 1'b1;
                    end
                    open_next     = eff_open;
                    expected_next = eff_expected;
                    count_next    = eff_count;
                    mask_next     = eff_mask;
                    count_inc     = {1'b0, eff_count} + 1'b1;

                    if (!eff_open || (8'(eff_expected) != seg_total))
                    begin
                        status_c = ST_NO_FRAME;
                    end
                    else if ((eff_mask & seg_bit) != '0)
                    begin
                        status_c = ST_DUPLICATE;
                    end
                    else
                    begin
                        if (pos < frame_end)
                        begin
                            wr_c   = 1'b1;
                            req.en = 1'b1;
                        end
                        else
                        begin
                            status_c = ST_BEYOND_END;
                        end
                        if (segment_end)
                        begin
                            mask_next  = eff_mask | seg_bit;
                            count_next = count_inc[CNT_W-1:0];
                            if (count_inc >= {1'b0, eff_expected})
                            begin
                                sel_next   = !sel_reg;
                                done_c     = 1'b1;
                                refresh_c  = !suppress_reg;
                                count_next = '0;
                                mask_next  = '0;
                                open_next  = 1'b0;
                                status_c   = ST_COMPLETE;
                            end
                        end
                    end
                end
            end
            ACT_READ:
            begin
                read_c   = rd_pos < frame_end;
                lane_c   = rd_pos[LANE_W-1:0];
                req.en   = 1'b1;
                req.bank = !sel_reg;
                req.row  = rd_pos[FRAME_AW-1:LANE_W];
            end
            ACT_REMOTE_ON:
            begin
                if (!remote_reg)
                begin
                    remote_next   = 1'b1;
                    req.clr       = 2'b11;
                    open_next     = 1'b0;
                    expected_next = '0;
                    count_next    = '0;
                    mask_next     = '0;
                    refresh_c     = !suppress_reg;
                end
            end
            ACT_REMOTE_OFF:
            begin
                if (remote_reg)
                begin
                    remote_next = 1'b0;
                    refresh_c   = !suppress_reg;
                end
            end
            default:
            begin
                status_c = ST_OK;
            end
        endcase

        if (!accept)
        begin
            req.en  = 1'b0;
            req.clr = 2'b00;
        end
    end

    assign wr.en   = s1_adv && s1_wr_reg;
    assign wr.lane = s1_lane_reg;
    assign wr.data = s1_value_reg;

    fsr_row_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .wr       (wr),
        .row_data (row_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            suppress_reg  <= 1'b0;
            remote_reg    <= 1'b0;
            open_reg      <= 1'b0;
            expected_reg  <= '0;
            count_reg     <= '0;
            mask_reg      <= '0;
            sel_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                suppress_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                remote_reg   <= remote_next;
                open_reg     <= open_next;
                expected_reg <= expected_next;
                count_reg    <= count_next;
                mask_reg     <= mask_next;
                sel_reg      <= sel_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg  <= status_c;
            s1_done_reg    <= done_c;
            s1_refresh_reg <= refresh_c;
            s1_read_reg    <= read_c;
            s1_wr_reg      <= wr_c;
            s1_lane_reg    <= lane_c;
            s1_value_reg   <= byte_value;
        end
        if (s1_adv)
        begin
            out_status_reg  <= s1_status_reg;
            out_done_reg    <= s1_done_reg;
            out_refresh_reg <= s1_refresh_reg;
            out_data_reg    <= s1_read_reg ? row_data[{s1_lane_reg, 3'b000} +: 8] : 8'd0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign read_data      = out_data_reg;
    assign frame_done     = out_done_reg;
    assign refresh_screen = out_refresh_reg;

endmodule

### hw/rtl/fsr_row_store.sv
// ----------------------------------------------------------------------------
// fsr_row_store
// Two banks of byte rows in one synchronous memory, with a valid bit per row
// and a read-modify-write path that forwards a row written in the same cycle.
// ----------------------------------------------------------------------------
module fsr_row_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fsr_pkg::mem_req_t          req,
    input  fsr_pkg::mem_wr_t           wr,
    output logic [fsr_pkg::ROW_W-1:0]  row_data
);
    import fsr_pkg::*;

    logic [ROW_W-1:0]    mem [0:2*ROWS-1];
    logic [ROW_W-1:0]    rdata_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                fwd_hit_reg;
    logic [ROW_W-1:0]    fwd_data_reg;
    logic [2*ROWS-1:0]   valid_reg;
    logic [2*ROWS-1:0]   valid_next;
    logic [ADDR_W-1:0]   req_addr;
    logic [ROW_W-1:0]    cur_row;
    logic [ROW_W-1:0]    merged_row;

    assign req_addr = {req.bank, req.row};

    // A row that is not valid reads as zero, which stands for a cleared bank.
    always_comb
    begin
        if (valid_reg[addr_reg])
        begin
            cur_row = fwd_hit_reg ? fwd_data_reg : rdata_reg;
        end
        else
        begin
            cur_row = '0;
        end
    end

    always_comb
    begin
        merged_row = cur_row;
        merged_row[{wr.lane, 3'b000} +: 8] = wr.data;
    end

    assign row_data = cur_row;

    // Clears belong to a later transfer than the write, so they win.
    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[addr_reg] = 1'b1;
        end
        if (req.clr[0])
        begin
            valid_next[ROWS-1:0] = '0;
        end
        if (req.clr[1])
        begin
            valid_next[2*ROWS-1:ROWS] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[addr_reg] <= merged_row;
        end
        if (req.en)
        begin
            rdata_reg <= mem[req_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            addr_reg     <= req_addr;
            fwd_data_reg <= merged_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.en)
            begin
                fwd_hit_reg <= wr.en && (addr_reg == req_addr);
            end
        end
    end

endmodule
